/* hdl/bap_pkg.sv */
// package with shared types and constants for the box averaging pixelator
`default_nettype none
package bap_pkg;
  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_BOX_WIDTH    = 3'd2,
    CFG_BOX_HEIGHT   = 3'd3,
    CFG_OFFSET_X     = 3'd4,
    CFG_OFFSET_Y     = 3'd5
  } cfg_index_t;

  localparam int SUM_W = 24;
  localparam int MAX_LINES = 4096;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } rgb_sum_t;

  typedef struct packed {
    logic [12:0] left;
    logic [12:0] top;
    logic        done;
  } box_tag_t;
endpackage
`default_nettype wire

/* hdl/bap_sum_ram.sv */
// band sum memory: one entry per box column, registered read
`default_nettype none
module bap_sum_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [AW-1:0]         wr_addr,
  input  wire bap_pkg::rgb_sum_t wr_data,
  input  wire [AW-1:0]         rd_addr,
  output bap_pkg::rgb_sum_t    rd_data
);
  import bap_pkg::*;
  rgb_sum_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* hdl/bap_divider.sv */
// restoring divider: three channel sums over the box area, one bit a cycle
`default_nettype none
module bap_divider (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire bap_pkg::rgb_sum_t sum,
  input  wire [17:0]             area,
  output logic                   done,
  output logic [7:0]             q_red,
  output logic [7:0]             q_green,
  output logic [7:0]             q_blue
);
  import bap_pkg::*;
  logic             busy;
  logic [4:0]       step;
  logic [SUM_W-1:0] qr, qg, qb;
  logic [17:0]      rr, rg, rb;
  logic [17:0]      dv;
  logic [18:0]      tr, tg, tb;

  always_comb begin
    tr = {rr, qr[SUM_W-1]};
    tg = {rg, qg[SUM_W-1]};
    tb = {rb, qb[SUM_W-1]};
  end

  function automatic logic [7:0] sat(input logic [SUM_W-1:0] q);
    sat = (q > SUM_W'(255)) ? 8'd255 : q[7:0];
  endfunction

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      qr <= sum.red; qg <= sum.green; qb <= sum.blue;
      rr <= '0; rg <= '0; rb <= '0;
      dv <= area;
    end else if (busy) begin
      if (tr >= {1'b0, dv}) begin
        rr <= 18'(tr - {1'b0, dv}); qr <= {qr[SUM_W-2:0], 1'b1};
      end else begin
        rr <= tr[17:0]; qr <= {qr[SUM_W-2:0], 1'b0};
      end
      if (tg >= {1'b0, dv}) begin
        rg <= 18'(tg - {1'b0, dv}); qg <= {qg[SUM_W-2:0], 1'b1};
      end else begin
        rg <= tg[17:0]; qg <= {qg[SUM_W-2:0], 1'b0};
      end
      if (tb >= {1'b0, dv}) begin
        rb <= 18'(tb - {1'b0, dv}); qb <= {qb[SUM_W-2:0], 1'b1};
      end else begin
        rb <= tb[17:0]; qb <= {qb[SUM_W-2:0], 1'b0};
      end
      step <= step + 5'd1;
      if (step == 5'(SUM_W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign q_red   = sat(qr);
  assign q_green = sat(qg);
  assign q_blue  = sat(qb);
endmodule
`default_nettype wire

/* hdl/box_average_pixelate.sv */
// top level of the box averaging pixelator
// Pixels arrive in raster order; each pixel passes S_IDLE (taken), S_READ (read the
// box column sum from the band memory) and S_ADD (add, write back), as the memory
// read is registered. A pixel that closes a box also starts the sum/area divider,
// and the next pixel is taken only once the divider is done and its result loaded,
// later still while the previous box waits unaccepted in the output
// register; that register otherwise frees the input side. The band memory
// needs no clearing: the first pixel of a box overwrites its entry.
`default_nettype none
module box_average_pixelate #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_BOX_SIDE = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  pixel_red,
  input  wire  [7:0]  pixel_green,
  input  wire  [7:0]  pixel_blue,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [12:0] box_left,
  output logic [12:0] box_top,
  output logic [7:0]  avg_red,
  output logic [7:0]  avg_green,
  output logic [7:0]  avg_blue,
  output logic        frame_done,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_data
);
  import bap_pkg::*;
  localparam int AW = $clog2(MAX_LINE_PIXELS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_ADD = 5'b00100,
    S_DIV = 5'b01000, S_HOLD = 5'b10000
  } state_t;
  state_t state;

  logic [12:0] frame_width, frame_height;
  logic [8:0]  box_width, box_height;
  logic [11:0] offset_x, offset_y;

  logic [12:0] column_count, line_count;
  logic [9:0]  column_in_box, line_in_box;
  logic [12:0] box_column_index;
  logic [7:0]  pr, pg, pb;

  logic [13:0] fw, fh;
  logic [10:0] bw, bh;
  always_comb begin
    fw = (frame_width == 0) ? 14'd1 :
         ({1'b0, frame_width} > 14'(MAX_LINE_PIXELS)) ? 14'(MAX_LINE_PIXELS)
                                                      : {1'b0, frame_width};
    fh = (frame_height == 0) ? 14'd1 :
         ({1'b0, frame_height} > 14'(MAX_LINES)) ? 14'(MAX_LINES)
                                                 : {1'b0, frame_height};
    bw = (box_width == 0) ? 11'd1 :
         ({2'b0, box_width} > 11'(MAX_BOX_SIDE)) ? 11'(MAX_BOX_SIDE)
                                                 : {2'b0, box_width};
    bh = (box_height == 0) ? 11'd1 :
         ({2'b0, box_height} > 11'(MAX_BOX_SIDE)) ? 11'(MAX_BOX_SIDE)
                                                  : {2'b0, box_height};
  end

  logic last_col, last_line, last_cib, last_lib, emit;
  always_comb begin
    last_col  = 14'(column_count) + 14'd1 >= fw;
    last_line = 14'(line_count) + 14'd1 >= fh;
    last_cib  = 11'(column_in_box) + 11'd1 >= bw;
    last_lib  = 11'(line_in_box) + 11'd1 >= bh;
    emit = (last_col || last_cib) && (last_line || last_lib);
  end

  logic [AW-1:0] idx;
  assign idx = ({1'b0, box_column_index} >= 14'(MAX_LINE_PIXELS)) ?
               AW'(MAX_LINE_PIXELS - 1) : box_column_index[AW-1:0];

  rgb_sum_t rd_data, wr_data;
  logic wr_en;
  bap_sum_ram #(.DEPTH(MAX_LINE_PIXELS), .AW(AW)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(idx), .wr_data(wr_data),
    .rd_addr(idx), .rd_data(rd_data));

  always_comb begin
    if (line_in_box == 0 && column_in_box == 0) begin
      wr_data.red = SUM_W'(pr); wr_data.green = SUM_W'(pg);
      wr_data.blue = SUM_W'(pb);
    end else begin
      wr_data.red   = rd_data.red + SUM_W'(pr);
      wr_data.green = rd_data.green + SUM_W'(pg);
      wr_data.blue  = rd_data.blue + SUM_W'(pb);
    end
  end
  assign wr_en = (state == S_ADD);

  logic [12:0] top_line;
  logic [22:0] left_prod;
  assign top_line = (line_count >= 13'(line_in_box)) ?
                    13'(line_count - 13'(line_in_box)) : 13'd0;
  assign left_prod = 23'(box_column_index) * 23'(bw);

  logic div_start, div_done;
  logic [7:0] qr, qg, qb;
  logic [17:0] area;
  logic [21:0] area_full;
  assign area_full = 22'(bw) * 22'(bh);
  assign area = area_full[17:0];
  assign div_start = (state == S_ADD) && emit;
  bap_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .sum(wr_data), .area(area),
    .done(div_done), .q_red(qr), .q_green(qg), .q_blue(qb));

  box_tag_t tag;
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      column_count <= '0; line_count <= '0;
      column_in_box <= '0; line_in_box <= '0; box_column_index <= '0;
      frame_width <= 13'd640; frame_height <= 13'd480;
      box_width <= 9'd64; box_height <= 9'd48;
      offset_x <= '0; offset_y <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          CFG_BOX_WIDTH:    box_width <= cfg_data[8:0];
          CFG_BOX_HEIGHT:   box_height <= cfg_data[8:0];
          CFG_OFFSET_X:     offset_x <= cfg_data[11:0];
          CFG_OFFSET_Y:     offset_y <= cfg_data[11:0];
          default: ;
        endcase
      end
      // a box loaded in S_HOLD sets valid there instead
      if (out_valid && out_ready && state != S_HOLD) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          pr <= pixel_red; pg <= pixel_green; pb <= pixel_blue;
          state <= S_READ;
        end
        S_READ: state <= S_ADD;
        S_ADD: begin
          if (emit) begin
            tag.left <= 13'(left_prod + 23'(offset_x));
            tag.top  <= 13'(top_line + 13'(offset_y));
            tag.done <= last_col && last_line;
            state <= S_DIV;
          end else state <= S_IDLE;
          if (last_col) begin
            column_count <= '0; column_in_box <= '0; box_column_index <= '0;
            if (last_line) begin
              line_count <= '0; line_in_box <= '0;
            end else begin
              line_count <= line_count + 13'd1;
              line_in_box <= last_lib ? 10'd0 : line_in_box + 10'd1;
            end
          end else begin
            column_count <= column_count + 13'd1;
            if (last_cib) begin
              column_in_box <= '0;
              box_column_index <= box_column_index + 13'd1;
            end else column_in_box <= column_in_box + 10'd1;
          end
        end
        S_DIV: if (div_done) state <= S_HOLD;
        S_HOLD: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          box_left <= tag.left; box_top <= tag.top; frame_done <= tag.done;
          avg_red <= qr; avg_green <= qg; avg_blue <= qb;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/bap_checker.sv */
// port checker for the box averaging pixelator, bound to the top level
`default_nettype none
module bap_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [12:0] box_left,
  input wire [7:0]  avg_red
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(box_left) && $stable(avg_red))
    else $error("result changed while stalled");
  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second pixel taken while one is at work");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");
endmodule

bind box_average_pixelate bap_checker u_bap_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .box_left(box_left),
  .avg_red(avg_red));
`default_nettype wire
